// ===== design/avs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// avs_pkg: shared types for the ascending value sorter
// Payload structs, controller state codes and controller commands.
// ----------------------------------------------------------------------------
package avs_pkg;

    localparam int VALUE_BITS = 16;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic                  last;
    } avs_in_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] sorted_value;
        logic                  end_of_set;
        logic                  overflow;
    } avs_out_t;

    typedef enum logic [0:0] {
        ST_LOAD  = 1'b0,
        ST_DRAIN = 1'b1
    } avs_state_t;

    typedef struct packed {
        logic insert;
        logic shift;
    } avs_cmd_t;

endpackage
`default_nettype wire

// ===== design/avs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// avs_ctrl: sorter controller
// Load/drain state machine, fill count and dropped-value flag.
// ----------------------------------------------------------------------------
module avs_ctrl #(
    parameter int DEPTH = 64,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              in_last,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   end_of_set,
    output logic                   overflow,
    output avs_pkg::avs_cmd_t      cmd,
    output logic [CW-1:0]          count
);

    avs_pkg::avs_state_t state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                flag_reg, flag_next;
    logic                in_acc, out_acc;
    logic                full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= avs_pkg::ST_LOAD;
            count_reg <= '0;
            flag_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            flag_reg  <= flag_next;
        end
    end

    assign full    = (count_reg == CW'(DEPTH));
    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        flag_next  = flag_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        cmd        = '0;
        case (state_reg)
            avs_pkg::ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_acc)
                begin
                    // store while there is room, otherwise drop and remember
                    if (!full)
                    begin
                        cmd.insert = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        flag_next = 1'b1;
                    end
                    if (in_last)
                    begin
                        state_next = avs_pkg::ST_DRAIN;
                    end
                end
            end
            avs_pkg::ST_DRAIN:
            begin
                out_valid = 1'b1;
                if (out_acc)
                begin
                    cmd.shift  = 1'b1;
                    count_next = count_reg - CW'(1);
                    if (count_reg == CW'(1))
                    begin
                        flag_next  = 1'b0;
                        state_next = avs_pkg::ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = avs_pkg::ST_LOAD;
            end
        endcase
    end

    assign end_of_set = (count_reg == CW'(1));
    assign overflow   = flag_reg;
    assign count      = count_reg;

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output sides open together");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("fill count beyond capacity");

    a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && in_last) |=> (out_valid && count_reg != '0))
        else $error("closing request did not start drain");

    a_end_reloads: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && end_of_set) |=> (in_ready && count_reg == '0 && !flag_reg))
        else $error("set end did not return to load");

    a_drop_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && full) |=> flag_reg)
        else $error("dropped value not flagged");

endmodule
`default_nettype wire

// ===== design/avs_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// avs_dpath: sorted cell row
// Keep values in ascending order; insert in place, shift out at the head.
// ----------------------------------------------------------------------------
module avs_dpath #(
    parameter int DEPTH = 64,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  wire logic                            clk,
    input  wire avs_pkg::avs_cmd_t               cmd,
    input  wire logic [CW-1:0]                   count,
    input  wire logic [avs_pkg::VALUE_BITS-1:0]  in_value,
    output logic [avs_pkg::VALUE_BITS-1:0]       head
);

    logic [avs_pkg::VALUE_BITS-1:0] cell_reg  [DEPTH];
    logic [avs_pkg::VALUE_BITS-1:0] cell_next [DEPTH];
    logic [DEPTH-1:0]               gt;

    // a cell moves when it is empty or holds a larger value than the new one
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            gt[i] = (CW'(i) >= count) || (cell_reg[i] > in_value);
        end
    end

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            cell_next[i] = cell_reg[i];
            if (cmd.insert)
            begin
                if (gt[i])
                begin
                    if (i == 0)
                    begin
                        cell_next[i] = in_value;
                    end
                    else if (!gt[i-1])
                    begin
                        cell_next[i] = in_value;
                    end
                    else
                    begin
                        cell_next[i] = cell_reg[i-1];
                    end
                end
            end
            else if (cmd.shift)
            begin
                if (i < DEPTH - 1)
                begin
                    cell_next[i] = cell_reg[i+1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            cell_reg[i] <= cell_next[i];
        end
    end

    assign head = cell_reg[0];

endmodule
`default_nettype wire

// ===== design/ascending_value_sorter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ascending_value_sorter: collect a set of values and return them ascending
// Load takes one request per cycle; each value drops into place in a row
// of compare cells. Drain returns one result per cycle from the row head
// while out_ready is high; the first result is valid the cycle after the
// closing request. Load and drain share the single cell row, which inserts
// or shifts but never both, so a new set waits until the last has drained.
// Reset: state returns to load, fill count and overflow flag clear;
// cell contents are not reset and are only read once written.
// ----------------------------------------------------------------------------
module ascending_value_sorter #(
    parameter int DEPTH = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire avs_pkg::avs_in_t  in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output avs_pkg::avs_out_t      out_data
);

    localparam int CW = $clog2(DEPTH + 1);

    avs_pkg::avs_cmd_t              cmd;
    logic [CW-1:0]                  count;
    logic [avs_pkg::VALUE_BITS-1:0] head;
    logic                           end_of_set;
    logic                           overflow;

    // controller: decide per request whether to insert or drop, and when to drain
    avs_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_last    (in_data.last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .end_of_set (end_of_set),
        .overflow   (overflow),
        .cmd        (cmd),
        .count      (count)
    );

    // datapath: the head cell always holds the smallest remaining value
    avs_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk      (clk),
        .cmd      (cmd),
        .count    (count),
        .in_value (in_data.value),
        .head     (head)
    );

    // results come straight from registers: head cell, count and flag
    always_comb
    begin
        out_data.sorted_value = head;
        out_data.end_of_set   = end_of_set;
        out_data.overflow     = overflow;
    end

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: regression for the ascending value sorter
// Sends sets of values, predicts the ascending result stream of every closed
// set, and checks each result field against it while both sides idle at random.
// ----------------------------------------------------------------------------
module tb;

    localparam int VB           = avs_pkg::VALUE_BITS;
    localparam int SET_CAPACITY = 64;
    localparam int RANDOM_ITEMS = 470;
    localparam int IDLE_PCT     = 13;
    localparam int DRAIN_TAIL   = 20;
    // Set far above the length of the slowest correct run.
    localparam int CYCLE_LIMIT  = 300000;

    // One row of the directed table: the request, and a typed-in result for
    // rows whose answer is obvious (a lone value that closes its own set).
    typedef struct packed {
        avs_pkg::avs_in_t  req;
        logic              typed;
        avs_pkg::avs_out_t want;
    } plan_row_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    avs_pkg::avs_in_t  in_data;
    logic              out_valid;
    logic              out_ready;
    avs_pkg::avs_out_t out_data;

    // When set, neither side idles: gives one long back-to-back stretch.
    logic calm;

    // Predictor state: values held for the open set and the dropped mark.
    logic [VB-1:0]     held_values[$];
    logic              set_dropped;
    avs_pkg::avs_out_t sorted_batch[$];

    // Results still owed by the block, oldest first.
    avs_pkg::avs_out_t pending_results[$];
    plan_row_t         directed_plan[$];

    int cycle_count     = 0;
    int mismatch_count  = 0;
    int requests_sent   = 0;
    int results_checked = 0;
    int sets_closed     = 0;
    int overflow_sets   = 0;

    ascending_value_sorter #(
        .DEPTH(SET_CAPACITY)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor: absorb one accepted request. Store the value while there is
    // room, otherwise drop it and mark the set. A closing request sorts the
    // held values and leaves the result stream of the set in sorted_batch.
    // ------------------------------------------------------------------------
    function automatic int absorb_value(input avs_pkg::avs_in_t req);
        logic [VB-1:0]     key;
        avs_pkg::avs_out_t res;
        int                a;
        int                b;
        sorted_batch.delete();
        if (held_values.size() < SET_CAPACITY)
            held_values.push_back(req.value);
        else
            set_dropped = 1'b1;
        if (!req.last)
            return 0;
        // Insertion sort; equal values keep repeating, order among them
        // does not matter since they are identical.
        for (a = 1; a < held_values.size(); a++)
        begin
            key = held_values[a];
            b = a;
            while (b > 0 && held_values[b-1] > key)
            begin
                held_values[b] = held_values[b-1];
                b--;
            end
            held_values[b] = key;
        end
        for (a = 0; a < held_values.size(); a++)
        begin
            res.sorted_value = held_values[a];
            res.end_of_set   = (a == held_values.size() - 1);
            res.overflow     = set_dropped;
            sorted_batch.push_back(res);
        end
        held_values.delete();
        set_dropped = 1'b0;
        return sorted_batch.size();
    endfunction

    function automatic plan_row_t plain_row(input logic [VB-1:0] value,
                                            input logic last);
        plan_row_t row;
        row.req.value = value;
        row.req.last  = last;
        row.typed     = 1'b0;
        row.want      = '0;
        return row;
    endfunction

    // A value that opens and closes its own set comes straight back as the
    // only result, marked end of set, with no overflow.
    function automatic plan_row_t closing_single(input logic [VB-1:0] value);
        plan_row_t row;
        row = plain_row(value, 1'b1);
        row.typed             = 1'b1;
        row.want.sorted_value = value;
        row.want.end_of_set   = 1'b1;
        row.want.overflow     = 1'b0;
        return row;
    endfunction

    // ------------------------------------------------------------------------
    // Offer one request: idle at random first, then hold valid and payload
    // until the block takes it. Valid stays high between back-to-back requests.
    // ------------------------------------------------------------------------
    task automatic offer_request(input avs_pkg::avs_in_t req, input logic typed,
                                 input avs_pkg::avs_out_t want);
        int produced;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // Accepted at this edge: advance the predictor.
        requests_sent++;
        produced = absorb_value(req);
        if (req.last)
            sets_closed++;
        if (produced > 0 && sorted_batch[0].overflow)
            overflow_sets++;
        if (typed)
            pending_results.push_back(want);
        else
            foreach (sorted_batch[k])
                pending_results.push_back(sorted_batch[k]);
    endtask

    // One random set. Size picks mostly short sets, sometimes a set that
    // fills the store exactly, and sometimes one that runs past it so that
    // trailing values (the closing one included) are dropped.
    task automatic offer_random_set(input int forced_size);
        avs_pkg::avs_in_t req;
        int               size;
        int               pick;
        int               flavor;
        int               k;
        pick = $urandom_range(0, 99);
        if (forced_size > 0)
            size = forced_size;
        else if (pick < 5)
            size = SET_CAPACITY;
        else if (pick < 12)
            size = $urandom_range(SET_CAPACITY + 1, SET_CAPACITY + 6);
        else if (pick < 16)
            size = $urandom_range(17, SET_CAPACITY - 1);
        else
            size = $urandom_range(1, 16);
        flavor = $urandom_range(0, 3);
        for (k = 0; k < size; k++)
        begin
            case (flavor)
                0: req.value = VB'($urandom_range(0, 7));  // many repeats
                1:
                begin
                    case ($urandom_range(0, 5))
                        0: req.value = '0;
                        1: req.value = '1;
                        2: req.value = VB'(1);
                        3: req.value = {VB{1'b1}} - VB'(1);
                        4: req.value = VB'(1) << (VB - 1);
                        default: req.value = (VB'(1) << (VB - 1)) - VB'(1);
                    endcase
                end
                default: req.value = VB'($urandom);
            endcase
            req.last = (k == size - 1);
            offer_request(req, 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: stall at random, and check every accepted result against
    // the oldest expectation, field by field.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        avs_pkg::avs_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none, actual %h/%b/%b",
                         $time, out_data.sorted_value, out_data.end_of_set,
                         out_data.overflow);
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (out_data.sorted_value !== want.sorted_value)
                begin
                    mismatch_count++;
                    $display("%0t: sorted_value expected %h actual %h", $time,
                             want.sorted_value, out_data.sorted_value);
                end
                if (out_data.end_of_set !== want.end_of_set)
                begin
                    mismatch_count++;
                    $display("%0t: end_of_set expected %b actual %b", $time,
                             want.end_of_set, out_data.end_of_set);
                end
                if (out_data.overflow !== want.overflow)
                begin
                    mismatch_count++;
                    $display("%0t: overflow expected %b actual %b", $time,
                             want.overflow, out_data.overflow);
                end
            end
        end
        out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Watchdog: drop the run if the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d results outstanding", $time,
                     pending_results.size());
            $display("ascending_value_sorter regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int random_base;
        int set_index;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        out_ready   = 1'b0;
        calm        = 1'b0;
        set_dropped = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: lone values, extremes first, right after reset, then sets that
        // mix extremes, repeat values, arrive sorted or reversed.
        directed_plan.push_back(closing_single(16'h0000));
        directed_plan.push_back(closing_single(16'hFFFF));
        directed_plan.push_back(closing_single(16'h1234));
        directed_plan.push_back(plain_row(16'hFFFF, 1'b0));
        directed_plan.push_back(plain_row(16'h0000, 1'b0));
        directed_plan.push_back(plain_row(16'h8000, 1'b0));
        directed_plan.push_back(plain_row(16'h7FFF, 1'b0));
        directed_plan.push_back(plain_row(16'h0001, 1'b0));
        directed_plan.push_back(plain_row(16'hFFFE, 1'b1));
        directed_plan.push_back(plain_row(16'h5555, 1'b0));
        directed_plan.push_back(plain_row(16'h5555, 1'b0));
        directed_plan.push_back(plain_row(16'hAAAA, 1'b0));
        directed_plan.push_back(plain_row(16'h5555, 1'b0));
        directed_plan.push_back(plain_row(16'h5555, 1'b1));
        directed_plan.push_back(plain_row(16'h0001, 1'b0));
        directed_plan.push_back(plain_row(16'h0002, 1'b0));
        directed_plan.push_back(plain_row(16'h0003, 1'b1));
        directed_plan.push_back(plain_row(16'h0300, 1'b0));
        directed_plan.push_back(plain_row(16'h0200, 1'b0));
        directed_plan.push_back(plain_row(16'h0100, 1'b1));
        directed_plan.push_back(plain_row(16'hFFFF, 1'b0));
        directed_plan.push_back(plain_row(16'hFFFF, 1'b1));
        directed_plan.push_back(closing_single(16'hA5A5));
        foreach (directed_plan[i])
            offer_request(directed_plan[i].req, directed_plan[i].typed,
                          directed_plan[i].want);

        // Random sets. The first fills the store exactly, the second runs one
        // past it so the closing value itself is dropped; the rest are drawn.
        // A block of requests in the middle runs with no idling on either side.
        random_base = requests_sent;
        set_index   = 0;
        while (requests_sent - random_base < RANDOM_ITEMS)
        begin
            calm = (requests_sent - random_base >= 150) &&
                   (requests_sent - random_base < 300);
            if (set_index == 0)
                offer_random_set(SET_CAPACITY);
            else if (set_index == 1)
                offer_random_set(SET_CAPACITY + 1);
            else
                offer_random_set(0);
            set_index++;
        end
        calm = 1'b0;
        @(posedge clk);
        in_valid <= 1'b0;

        // Wait out the remaining results, then a short tail to catch extras.
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);

        $display("Sent %0d requests in %0d sets (%0d with dropped values).",
                 requests_sent, sets_closed, overflow_sets);
        $display("Checked %0d sorted results, %0d mismatches.",
                 results_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("ascending_value_sorter regression: pass");
        else
            $display("ascending_value_sorter regression: fail");
        $finish;
    end

endmodule
